/* src/pawt_pkg.sv */
`timescale 1ns / 1ps
package pawt_pkg;

	// Table geometry; the slot index is the low bits of the ack, so the depth is a power of two
	localparam int TRACK_SLOTS = 64;
	localparam int SLOT_W      = $clog2(TRACK_SLOTS);

	localparam logic [15:0] ACK_NONE   = 16'hFFFF;
	localparam logic [15:0] HALF_RANGE = 16'hFFFF / 16'd2;
	localparam logic [15:0] HIST_BITS  = 16'd16;
	localparam logic [6:0]  LOSS_MAX   = 7'd127;

	// Candidate index of the last history ack (index 0 is the partner's last ack)
	localparam logic [4:0]  CAND_LAST  = 5'd16;
	localparam logic [4:0]  CAND_MAX   = 5'd17;

	localparam logic        MODE_SEND  = 1'b0;
	localparam logic        MODE_RECV  = 1'b1;

	localparam logic [1:0]  DUP_NONE    = 2'd0;
	localparam logic [1:0]  DUP_HIGHEST = 2'd1;
	localparam logic [1:0]  DUP_HISTORY = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONFIRM,
		ST_DRAIN
	} pawt_state_t;

	typedef struct packed {
		logic        mode;
		logic [31:0] now;
		logic [15:0] remote_ack;
		logic [15:0] remote_last_ack;
		logic [15:0] remote_history;
	} pawt_in_t;

	typedef struct packed {
		logic [15:0] sent_ack;
		logic [15:0] recv_last_ack;
		logic [15:0] recv_history;
		logic [1:0]  dup_status;
		logic [4:0]  confirmed_count;
		logic [15:0] last_confirmed;
		logic [31:0] round_trip;
		logic [6:0]  window_losses;
	} pawt_out_t;

	typedef struct packed {
		logic [15:0] ack;
		logic [31:0] sent_time;
	} pawt_slot_t;

endpackage

/* src/packet_ack_window_tracker.sv */
`timescale 1ns / 1ps
// Timing: a send gives its result in the cycle after acceptance, and so does a receive
// that duplicates the highest ack or carries no last ack; any other receive gives it after
// the sweep reads all candidate slots through the synchronous slot memory read port and
// passes one compare stage and the result register. Throughput: one item per cycle for
// sends while idle; a confirming receive holds busy until its result. Reset: arst_n clears
// control and result state (live bits included), not slot memory; the receiver cannot stall.
module packet_ack_window_tracker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  pawt_pkg::pawt_in_t  item,
	output logic              done,
	output pawt_pkg::pawt_out_t result
);

	// Slot table: ack and send time, one synchronous read port
	pawt_pkg::pawt_slot_t slot_mem [pawt_pkg::TRACK_SLOTS];
	logic [pawt_pkg::TRACK_SLOTS-1:0] live_q;

	pawt_pkg::pawt_state_t state_q, state_d;

	logic [15:0] next_ack_q;
	logic [15:0] highest_q;
	logic [15:0] hist_q;
	logic [15:0] conf_q;
	logic [31:0] rtt_q;
	logic [6:0]  loss_cnt_q;
	logic [6:0]  loss_latched_q;
	logic [15:0] sent_q;
	logic [1:0]  dup_q;
	logic [4:0]  count_q;
	logic        done_q;

	// Receive context held during the confirmation sweep
	logic [31:0] now_q;
	logic [15:0] r_last_q;
	logic [15:0] r_hist_q;
	logic [4:0]  idx_q;

	// Compare stage
	logic                 en_s1;
	logic [15:0]          cand_s1;
	logic [pawt_pkg::SLOT_W-1:0] slot_s1;
	pawt_pkg::pawt_slot_t rd_s1;

	logic accept;
	logic [15:0] diff, back, hist_d, highest_d, bit_back;
	logic [1:0]  dup_d;
	logic        go_confirm;
	logic [15:0] cand;
	logic        cand_en;
	logic [pawt_pkg::SLOT_W-1:0] send_slot;
	logic        send_wraps;
	logic [6:0]  loss_base;
	logic        hit_s2;

	assign accept    = start && !busy;
	assign send_slot = next_ack_q[pawt_pkg::SLOT_W-1:0];
	assign send_wraps = (send_slot == pawt_pkg::SLOT_W'(pawt_pkg::TRACK_SLOTS - 1));
	assign loss_base = send_wraps ? 7'd0 : loss_cnt_q;

	// Update received-ack number and history, flag duplicates
	always_comb begin
		diff      = item.remote_ack - highest_q;
		back      = highest_q - item.remote_ack;
		bit_back  = 16'd1 << 4'(back - 16'd1);
		highest_d = highest_q;
		hist_d    = hist_q;
		dup_d     = pawt_pkg::DUP_NONE;
		if (item.remote_ack != pawt_pkg::ACK_NONE) begin
			if (diff == 16'd0) begin
				dup_d = pawt_pkg::DUP_HIGHEST;
			end else if (diff < pawt_pkg::HALF_RANGE) begin
				highest_d = item.remote_ack;
				if (diff >= pawt_pkg::HIST_BITS) begin
					hist_d = 16'd0;
				end else begin
					hist_d = hist_q << diff[3:0];
				end
				if (diff <= pawt_pkg::HIST_BITS) begin
					hist_d = hist_d | (16'd1 << 4'(diff - 16'd1));
				end
			end else if (back >= 16'd1 && back <= pawt_pkg::HIST_BITS) begin
				if ((hist_q & bit_back) != 16'd0) begin
					dup_d = pawt_pkg::DUP_HISTORY;
				end else begin
					hist_d = hist_q | bit_back;
				end
			end
		end
	end

	assign go_confirm = (item.mode == pawt_pkg::MODE_RECV) && (dup_d != pawt_pkg::DUP_HIGHEST)
		&& (item.remote_last_ack != pawt_pkg::ACK_NONE);

	// Pick the candidate ack for the current sweep step
	always_comb begin
		cand = r_last_q - 16'(idx_q);
		if (cand == pawt_pkg::ACK_NONE) begin
			cand = pawt_pkg::ACK_NONE - 16'd1;
		end
		cand_en = (idx_q == 5'd0) || r_hist_q[4'(idx_q - 5'd1)];
	end

	assign hit_s2 = en_s1 && live_q[slot_s1] && (rd_s1.ack == cand_s1);

	// Next state and handshake
	always_comb begin
		state_d = state_q;
		busy    = (state_q != pawt_pkg::ST_IDLE);
		case (state_q)
			pawt_pkg::ST_IDLE: begin
				if (accept && go_confirm) begin
					state_d = pawt_pkg::ST_CONFIRM;
				end
			end
			pawt_pkg::ST_CONFIRM: begin
				if (idx_q == pawt_pkg::CAND_LAST) begin
					state_d = pawt_pkg::ST_DRAIN;
				end
			end
			pawt_pkg::ST_DRAIN: begin
				state_d = pawt_pkg::ST_IDLE;
			end
			default: begin
				state_d = pawt_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pawt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Write on send, read candidate slot every cycle
	always_ff @(posedge clk) begin
		if (accept && item.mode == pawt_pkg::MODE_SEND) begin
			slot_mem[send_slot] <= '{ack: next_ack_q, sent_time: item.now};
		end
		rd_s1 <= slot_mem[cand[pawt_pkg::SLOT_W-1:0]];
	end

	// Advance the compare stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1 <= 1'b0;
		end else begin
			en_s1 <= (state_q == pawt_pkg::ST_CONFIRM) && cand_en;
		end
	end

	always_ff @(posedge clk) begin
		cand_s1 <= cand;
		slot_s1 <= cand[pawt_pkg::SLOT_W-1:0];
	end

	// Hold receive context and step the sweep index
	always_ff @(posedge clk) begin
		if (accept) begin
			now_q    <= item.now;
			r_last_q <= item.remote_last_ack;
			r_hist_q <= item.remote_history;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 5'd0;
		end else if (state_q == pawt_pkg::ST_CONFIRM) begin
			idx_q <= idx_q + 5'd1;
		end else begin
			idx_q <= 5'd0;
		end
	end

	// Tracker state, result registers and strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q         <= '0;
			next_ack_q     <= 16'd0;
			highest_q      <= pawt_pkg::ACK_NONE;
			hist_q         <= 16'd0;
			conf_q         <= pawt_pkg::ACK_NONE;
			rtt_q          <= 32'd0;
			loss_cnt_q     <= 7'd0;
			loss_latched_q <= 7'd0;
			sent_q         <= 16'd0;
			dup_q          <= pawt_pkg::DUP_NONE;
			count_q        <= 5'd0;
			done_q         <= 1'b0;
		end else begin
			// Strobe after a send, a receive with nothing to confirm, or the sweep end
			done_q <= (accept && (item.mode == pawt_pkg::MODE_SEND || !go_confirm))
				|| (state_q == pawt_pkg::ST_DRAIN);
			if (accept) begin
				count_q <= 5'd0;
				if (item.mode == pawt_pkg::MODE_SEND) begin
					sent_q <= next_ack_q;
					dup_q  <= pawt_pkg::DUP_NONE;
					if (send_wraps) begin
						loss_latched_q <= loss_cnt_q;
					end
					if (live_q[send_slot] && loss_base < pawt_pkg::LOSS_MAX) begin
						loss_cnt_q <= loss_base + 7'd1;
					end else begin
						loss_cnt_q <= loss_base;
					end
					live_q[send_slot] <= 1'b1;
					if (next_ack_q + 16'd1 == pawt_pkg::ACK_NONE) begin
						next_ack_q <= 16'd0;
					end else begin
						next_ack_q <= next_ack_q + 16'd1;
					end
				end else begin
					sent_q    <= 16'd0;
					dup_q     <= dup_d;
					highest_q <= highest_d;
					hist_q    <= hist_d;
				end
			end
			// Free a confirmed slot and take its round trip
			if (hit_s2) begin
				live_q[slot_s1] <= 1'b0;
				conf_q  <= cand_s1;
				rtt_q   <= now_q - rd_s1.sent_time;
				count_q <= count_q + 5'd1;
			end
		end
	end

	// Drive the result from the state registers
	always_comb begin
		result.sent_ack        = sent_q;
		result.recv_last_ack   = highest_q;
		result.recv_history    = hist_q;
		result.dup_status      = dup_q;
		result.confirmed_count = count_q;
		result.last_confirmed  = conf_q;
		result.round_trip      = rtt_q;
		result.window_losses   = loss_latched_q;
	end

	assign done = done_q;

endmodule

/* src/pawt_checker.sv */
`timescale 1ns / 1ps
module pawt_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input pawt_pkg::pawt_out_t result
);

	// Every accepted transaction either finishes at once or starts a sweep
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (done || busy))
		else $error("accepted transaction neither finished nor started a sweep");

	// A sweep always ends with a result
	a_sweep_ends_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("sweep ended without a result");

	// Results appear only while idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// A duplicate of the highest ack confirms nothing
	a_dup_no_confirm: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.dup_status == pawt_pkg::DUP_HIGHEST) |-> (result.confirmed_count == 5'd0))
		else $error("duplicate packet confirmed slots");

	// At most the last ack and its history can be confirmed
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.confirmed_count <= pawt_pkg::CAND_MAX))
		else $error("confirmed count out of range");

endmodule

bind packet_ack_window_tracker pawt_checker u_pawt_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

/* bench/tb_packet_ack_window_tracker.sv */
`timescale 1ns / 1ps
module tb_packet_ack_window_tracker;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 25;
	localparam int MAX_REPORTS    = 10;
	localparam int PHASE_ITEMS    = 430;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	pawt_pkg::pawt_in_t  item;
	logic                done;
	pawt_pkg::pawt_out_t result;

	packet_ack_window_tracker dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	// Tracker state mirrored by the bench
	logic [15:0] tx_seq;
	logic [15:0] rx_top;
	logic [15:0] rx_bits;
	logic [15:0] last_ok;
	logic [31:0] rtt_now;
	logic [6:0]  loss_run;
	logic [6:0]  loss_shown;
	logic [15:0] slot_tag [pawt_pkg::TRACK_SLOTS];
	logic [31:0] slot_stamp [pawt_pkg::TRACK_SLOTS];

	pawt_pkg::pawt_out_t pending_results [$];

	int          idle_pct;
	logic [31:0] tick_clock;
	int          items_issued;
	int          mismatches;
	int          quiet_cycles = 0;
	int          n_sent, n_recv, n_confirmed, n_dup_top, n_dup_hist, peak_loss, n_full_confirm;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Free a live slot that matches the ack and take its round trip
	function automatic logic retire_slot(input logic [15:0] a, input logic [31:0] t);
		logic [pawt_pkg::SLOT_W-1:0] s;
		s = a[pawt_pkg::SLOT_W-1:0];
		if (a == pawt_pkg::ACK_NONE || slot_tag[s] != a)
			return 1'b0;
		slot_tag[s] = pawt_pkg::ACK_NONE;
		last_ok     = a;
		rtt_now     = t - slot_stamp[s];
		return 1'b1;
	endfunction

	// Advance the tracker by one transaction and return the result it should give
	function automatic pawt_pkg::pawt_out_t track_packet(input pawt_pkg::pawt_in_t it);
		pawt_pkg::pawt_out_t         r;
		logic [pawt_pkg::SLOT_W-1:0] s;
		logic [15:0]                 diff;
		logic [15:0]                 back;
		logic [15:0]                 prev;
		logic [15:0]                 bit_mask;
		logic                        abort_rx;
		int                          k;
		r        = '0;
		abort_rx = 1'b0;
		if (it.mode == pawt_pkg::MODE_SEND) begin
			s          = tx_seq[pawt_pkg::SLOT_W-1:0];
			r.sent_ack = tx_seq;
			if (int'(s) == pawt_pkg::TRACK_SLOTS - 1) begin
				loss_shown = loss_run;
				loss_run   = '0;
			end
			if (slot_tag[s] != pawt_pkg::ACK_NONE && loss_run < pawt_pkg::LOSS_MAX)
				loss_run = loss_run + 7'd1;
			slot_tag[s]   = tx_seq;
			slot_stamp[s] = it.now;
			tx_seq        = tx_seq + 16'd1;
			if (tx_seq == pawt_pkg::ACK_NONE)
				tx_seq = '0;
			n_sent++;
		end else begin
			n_recv++;
			// Update our own received-ack window
			if (it.remote_ack != pawt_pkg::ACK_NONE) begin
				diff = it.remote_ack - rx_top;
				if (diff == 16'd0) begin
					r.dup_status = pawt_pkg::DUP_HIGHEST;
					abort_rx     = 1'b1;
				end else if (diff < pawt_pkg::HALF_RANGE) begin
					rx_top  = it.remote_ack;
					rx_bits = (diff >= pawt_pkg::HIST_BITS) ? 16'd0 : (rx_bits << diff);
					if (diff <= pawt_pkg::HIST_BITS)
						rx_bits = rx_bits | (16'd1 << (diff - 16'd1));
				end else begin
					back = rx_top - it.remote_ack;
					if (back >= 16'd1 && back <= pawt_pkg::HIST_BITS) begin
						bit_mask = 16'd1 << (back - 16'd1);
						if ((rx_bits & bit_mask) != 16'd0)
							r.dup_status = pawt_pkg::DUP_HISTORY;
						else
							rx_bits = rx_bits | bit_mask;
					end
				end
			end
			// Confirm the partner's last ack and every ack flagged in its history
			if (!abort_rx && it.remote_last_ack != pawt_pkg::ACK_NONE) begin
				if (retire_slot(it.remote_last_ack, it.now))
					r.confirmed_count = r.confirmed_count + 5'd1;
				for (k = 0; k < pawt_pkg::HIST_BITS; k++) begin
					if (it.remote_history[k]) begin
						prev = it.remote_last_ack - 16'(k + 1);
						if (prev == pawt_pkg::ACK_NONE)
							prev = pawt_pkg::ACK_NONE - 16'd1;
						if (retire_slot(prev, it.now))
							r.confirmed_count = r.confirmed_count + 5'd1;
					end
				end
			end
			if (r.dup_status == pawt_pkg::DUP_HIGHEST)
				n_dup_top++;
			if (r.dup_status == pawt_pkg::DUP_HISTORY)
				n_dup_hist++;
			if (r.confirmed_count == pawt_pkg::CAND_MAX)
				n_full_confirm++;
			n_confirmed += r.confirmed_count;
		end
		r.recv_last_ack  = rx_top;
		r.recv_history   = rx_bits;
		r.last_confirmed = last_ok;
		r.round_trip     = rtt_now;
		r.window_losses  = loss_shown;
		if (loss_shown > peak_loss)
			peak_loss = loss_shown;
		return r;
	endfunction

	// Advance the tick clock, wrapping through 2^32, with an occasional random jump
	function automatic logic [31:0] next_tick();
		if ($urandom_range(0, 99) < 5)
			return $urandom;
		tick_clock = tick_clock + $urandom_range(1, 4000);
		return tick_clock;
	endfunction

	function automatic pawt_pkg::pawt_in_t make_send();
		pawt_pkg::pawt_in_t it;
		it.mode            = pawt_pkg::MODE_SEND;
		it.now             = next_tick();
		it.remote_ack      = 16'($urandom);
		it.remote_last_ack = 16'($urandom);
		it.remote_history  = 16'($urandom);
		return it;
	endfunction

	function automatic pawt_pkg::pawt_in_t header(input logic [15:0] ack,
			input logic [15:0] last, input logic [15:0] hist);
		pawt_pkg::pawt_in_t it;
		it.mode            = pawt_pkg::MODE_RECV;
		it.now             = next_tick();
		it.remote_ack      = ack;
		it.remote_last_ack = last;
		it.remote_history  = hist;
		return it;
	endfunction

	// Well-formed receive: acks near our highest, last ack near what we sent
	function automatic pawt_pkg::pawt_in_t make_recv();
		logic [15:0] ack;
		logic [15:0] last;
		logic [15:0] hist;
		int          pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			ack = rx_top + 16'($urandom_range(1, 3));
		else if (pick < 65)
			ack = rx_top - 16'($urandom_range(1, 17));
		else if (pick < 72)
			ack = rx_top;
		else if (pick < 78)
			ack = rx_top + 16'($urandom_range(14, 18));
		else if (pick < 84)
			ack = rx_top + 16'($urandom_range(19, 40000));
		else if (pick < 90)
			ack = pawt_pkg::ACK_NONE;
		else
			ack = 16'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 40)
			last = tx_seq - 16'd1;
		else if (pick < 85)
			last = tx_seq - 16'd1 - 16'($urandom_range(0, 24));
		else if (pick < 95)
			last = pawt_pkg::ACK_NONE;
		else
			last = 16'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 25)
			hist = 16'hFFFF;
		else if (pick < 65)
			hist = 16'($urandom);
		else
			hist = 16'($urandom & $urandom & $urandom);
		return header(ack, last, hist);
	endfunction

	function automatic pawt_pkg::pawt_in_t make_noise();
		pawt_pkg::pawt_in_t it;
		it.mode            = 1'($urandom_range(0, 1));
		it.now             = $urandom;
		it.remote_ack      = 16'($urandom);
		it.remote_last_ack = 16'($urandom);
		it.remote_history  = 16'($urandom);
		return it;
	endfunction

	// Present one transaction, idle first at the current rate, and wait for acceptance
	task automatic send_item(input pawt_pkg::pawt_in_t it);
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
		end
		start <= 1'b1;
		item  <= it;
		do @(posedge clk); while (busy !== 1'b0);
		pending_results.insert(pending_results.size(), track_packet(it));
		items_issued++;
	endtask

	// Hold off until every outstanding result has come back
	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic run_burst(input int max_sends);
		repeat ($urandom_range(0, max_sends))
			send_item(make_send());
		repeat ($urandom_range(1, 4))
			send_item(make_recv());
	endtask

	// Headers on an empty table: reset values, and a last ack of zero whose history wraps
	task automatic test_idle_headers();
		send_item(header(pawt_pkg::ACK_NONE, pawt_pkg::ACK_NONE, 16'h0000));
		send_item(header(pawt_pkg::ACK_NONE, 16'd0, 16'hFFFF));
	endtask

	// Stamp acks, confirm all but the newest, then repeat the same confirmation
	task automatic test_send_confirm();
		repeat (9)
			send_item(make_send());
		send_item(header(pawt_pkg::ACK_NONE, 16'd7, 16'h007F));
		send_item(header(pawt_pkg::ACK_NONE, 16'd7, 16'h007F));
	endtask

	// Walk the received-ack window through shifts, duplicates, jumps and old acks
	task automatic test_ack_tracking();
		send_item(header(16'd100, pawt_pkg::ACK_NONE, 16'h0000));
		send_item(header(16'd101, pawt_pkg::ACK_NONE, 16'h0000));
		send_item(header(16'd104, pawt_pkg::ACK_NONE, 16'h0000));
		send_item(header(16'd104, 16'd8, 16'h0000));
		send_item(header(16'd102, 16'd8, 16'h0000));
		send_item(header(16'd102, pawt_pkg::ACK_NONE, 16'h0000));
		send_item(header(16'd120, pawt_pkg::ACK_NONE, 16'h0000));
		send_item(header(16'd137, pawt_pkg::ACK_NONE, 16'h0000));
		send_item(header(16'd121, pawt_pkg::ACK_NONE, 16'h0000));
		send_item(header(16'd120, pawt_pkg::ACK_NONE, 16'h0000));
		send_item(header(16'd32903, pawt_pkg::ACK_NONE, 16'h0000));
		send_item(header(16'd134, pawt_pkg::ACK_NONE, 16'hFFFF));
	endtask

	// Mixed traffic at one sender idle rate, mostly bursts with some noise
	task automatic test_random_traffic(input int pct);
		int mark;
		idle_pct = pct;
		mark     = items_issued;
		while (items_issued - mark < PHASE_ITEMS) begin
			if ($urandom_range(0, 99) < 15)
				send_item(make_noise());
			else
				run_burst(20);
			if ($urandom_range(0, 99) < 4)
				drain_results();
		end
		drain_results();
	endtask

	// Carry the received ack across the skipped none value, mark an old ack behind it
	task automatic test_ack_wrap();
		idle_pct = 0;
		send_item(header(16'd65530, pawt_pkg::ACK_NONE, 16'h0000));
		send_item(header(16'd65534, pawt_pkg::ACK_NONE, 16'h0000));
		send_item(header(16'd2, pawt_pkg::ACK_NONE, 16'h0000));
		send_item(header(16'd65533, tx_seq - 16'd1, 16'hFFFF));
		repeat (15)
			run_burst(12);
		drain_results();
	endtask

	// Check each result against the oldest expectation
	always @(posedge clk) begin : check_results
		pawt_pkg::pawt_out_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				if (mismatches < MAX_REPORTS)
					$display("[%0t] result with no transaction outstanding", $realtime);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (result !== want) begin
					if (mismatches < MAX_REPORTS) begin
						$display("[%0t] expected sent=%0d last=%h hist=%h dup=%0d conf=%0d lc=%h rtt=%h loss=%0d",
							$realtime, want.sent_ack, want.recv_last_ack, want.recv_history,
							want.dup_status, want.confirmed_count, want.last_confirmed,
							want.round_trip, want.window_losses);
						$display("          actual   sent=%0d last=%h hist=%h dup=%0d conf=%0d lc=%h rtt=%h loss=%0d",
							result.sent_ack, result.recv_last_ack, result.recv_history,
							result.dup_status, result.confirmed_count, result.last_confirmed,
							result.round_trip, result.window_losses);
					end
					mismatches++;
				end
			end
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (start && busy === 1'b0) || done === 1'b1) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL packet_ack_window_tracker");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n         = 1'b0;
		start          = 1'b0;
		item           = '0;
		idle_pct       = 0;
		tick_clock     = 32'hFFFF_F000;
		items_issued   = 0;
		mismatches     = 0;
		n_sent         = 0;
		n_recv         = 0;
		n_confirmed    = 0;
		n_dup_top      = 0;
		n_dup_hist     = 0;
		n_full_confirm = 0;
		peak_loss      = 0;
		tx_seq         = '0;
		rx_top         = pawt_pkg::ACK_NONE;
		rx_bits        = '0;
		last_ok        = pawt_pkg::ACK_NONE;
		rtt_now        = '0;
		loss_run       = '0;
		loss_shown     = '0;
		for (int i = 0; i < pawt_pkg::TRACK_SLOTS; i++) begin
			slot_tag[i]   = pawt_pkg::ACK_NONE;
			slot_stamp[i] = '0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_headers();
		test_send_confirm();
		test_ack_tracking();
		drain_results();
		test_random_traffic(32);
		test_random_traffic(84);
		test_random_traffic(0);
		test_ack_wrap();

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Covered %0d sends and %0d receives, %0d acks confirmed (%0d full windows)",
			n_sent, n_recv, n_confirmed, n_full_confirm);
		$display("Saw %0d repeats of the highest ack, %0d repeats in history, peak window loss %0d",
			n_dup_top, n_dup_hist, peak_loss);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("PASS packet_ack_window_tracker");
		else
			$display("FAIL packet_ack_window_tracker");
		$finish;
	end

endmodule

/* packet_ack_window_tracker.f */
src/pawt_pkg.sv
src/packet_ack_window_tracker.sv
src/pawt_checker.sv
bench/tb_packet_ack_window_tracker.sv
